### src/mqo_pkg.sv
// Shared types, constants and tables for the mecanum quadrature odometry block.
`default_nettype none
package mqo_pkg;
    localparam int COUNT_BITS_DEF = 32;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int NUM_WHEELS     = 4;
    localparam int CORDIC_STEPS   = 21;
    localparam int DIV_STEPS      = 23;
    localparam int NUM_RATES      = 7;
    localparam int RATE_W         = 24;
    localparam int DIST_W         = 56;
    localparam int SUM_W          = 58;
    localparam int ROT_W          = 47;
    localparam int ZW             = 24;
    localparam int ACC_W          = 60;
    localparam int DVS_W          = 36;

    localparam logic [23:0] DPC_RESET  = 24'd424523;
    localparam logic [15:0] GAIN_RESET = 16'd6935;

    localparam logic REG_DPC  = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_SAMPLE = 4'd1;
    localparam logic [3:0] OP_WHEEL  = 4'd2;
    localparam logic [3:0] OP_SUMS   = 4'd3;
    localparam logic [3:0] OP_PROD   = 4'd4;
    localparam logic [3:0] OP_CORDIC = 4'd5;
    localparam logic [3:0] OP_GAIN   = 4'd6;
    localparam logic [3:0] OP_POSE   = 4'd7;
    localparam logic [3:0] OP_RLOAD  = 4'd8;
    localparam logic [3:0] OP_RMULLO = 4'd9;
    localparam logic [3:0] OP_RMULHI = 4'd10;
    localparam logic [3:0] OP_RCHK   = 4'd11;
    localparam logic [3:0] OP_RDIV   = 4'd12;
    localparam logic [3:0] OP_RSTORE = 4'd13;

    localparam logic [2:0] RATE_VX   = 3'd0;
    localparam logic [2:0] RATE_VY   = 3'd1;
    localparam logic [2:0] RATE_YAW  = 3'd2;
    localparam logic [2:0] RATE_FL   = 3'd3;
    localparam logic [2:0] RATE_LAST = 3'd6;

    typedef struct packed {
        logic       capture;
        logic [3:0] op;
        logic [4:0] step;
        logic [2:0] sel;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic kind;
        logic dt_zero;
        logic out_free;
    } status_t;

    function automatic logic [21:0] atan_lut(input logic [4:0] i);
        logic [21:0] v;
        case (i)
            5'd0:    v = 22'd2097152;
            5'd1:    v = 22'd1238021;
            5'd2:    v = 22'd654136;
            5'd3:    v = 22'd332050;
            5'd4:    v = 22'd166669;
            5'd5:    v = 22'd83416;
            5'd6:    v = 22'd41718;
            5'd7:    v = 22'd20860;
            5'd8:    v = 22'd10430;
            5'd9:    v = 22'd5215;
            5'd10:   v = 22'd2608;
            5'd11:   v = 22'd1304;
            5'd12:   v = 22'd652;
            5'd13:   v = 22'd326;
            5'd14:   v = 22'd163;
            5'd15:   v = 22'd81;
            5'd16:   v = 22'd41;
            5'd17:   v = 22'd20;
            5'd18:   v = 22'd10;
            5'd19:   v = 22'd5;
            5'd20:   v = 22'd3;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

    // {old AB, new AB} -> {down, up}
    function automatic logic [1:0] quad_step(input logic [3:0] t);
        logic [1:0] v;
        case (t)
            4'b0001, 4'b0111, 4'b1110, 4'b1000: v = 2'b01;
            4'b0010, 4'b0100, 4'b1101, 4'b1011: v = 2'b10;
            default:                            v = 2'b00;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

### src/mecanum_quadrature_odometry.sv
// An encoder sample is captured on acceptance and decoded before the next input is taken.
// A period tick runs the wheel, sum, product, CORDIC, gain, pose and rate steps in order;
// the result appears on m_valid the cycle after it is loaded, once the output is free.
// No input is taken until a tick is done; a zero-time tick returns to idle with no output.
// Reset (aresetn, synchronous, active low) clears counts, phases, pose and output valid,
// and loads the register defaults.
`default_nettype none
module mecanum_quadrature_odometry #(
    parameter int COUNT_BITS = mqo_pkg::COUNT_BITS_DEF,
    parameter int ANGLE_BITS = mqo_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_kind,
    input  wire logic [3:0]            s_enc_a,
    input  wire logic [3:0]            s_enc_b,
    input  wire logic [19:0]           s_elapsed_us,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed [31:0]         m_x_pos,
    output logic signed [31:0]         m_y_pos,
    output logic [ANGLE_BITS-1:0]      m_heading,
    output logic signed [23:0]         m_vel_x,
    output logic signed [23:0]         m_vel_y,
    output logic signed [23:0]         m_yaw_rate,
    output logic signed [23:0]         m_speed_fl,
    output logic signed [23:0]         m_speed_fr,
    output logic signed [23:0]         m_speed_rl,
    output logic signed [23:0]         m_speed_rr,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    mqo_pkg::cmd_t    cmd;
    mqo_pkg::status_t status;

    logic [23:0] dpc_reg;
    logic [15:0] gain_reg;
    logic        dp_kind, dp_dt_zero;
    logic [31:0] pose_x, pose_y, pose_heading;
    logic [mqo_pkg::NUM_RATES-1:0][mqo_pkg::RATE_W-1:0] rates;
    logic        m_valid_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpc_reg  <= mqo_pkg::DPC_RESET;
            gain_reg <= mqo_pkg::GAIN_RESET;
        end else if (wr_en) begin
            if (paddr[2] == mqo_pkg::REG_DPC) dpc_reg <= pwdata[23:0];
            else gain_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == mqo_pkg::REG_GAIN) ? {16'b0, gain_reg} : {8'b0, dpc_reg};

    assign status.kind     = dp_kind;
    assign status.dt_zero  = dp_dt_zero;
    assign status.out_free = !m_valid_reg || m_ready;

    mqo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    mqo_datapath #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .kind_in      (s_kind),
        .enc_a_in     (s_enc_a),
        .enc_b_in     (s_enc_b),
        .dt_in        (s_elapsed_us),
        .dpc          (dpc_reg),
        .gain         (gain_reg),
        .kind         (dp_kind),
        .dt_zero      (dp_dt_zero),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .rates        (rates)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_x_pos    <= pose_x;
            m_y_pos    <= pose_y;
            m_heading  <= pose_heading[31 -: ANGLE_BITS];
            m_vel_x    <= rates[mqo_pkg::RATE_VX];
            m_vel_y    <= rates[mqo_pkg::RATE_VY];
            m_yaw_rate <= rates[mqo_pkg::RATE_YAW];
            m_speed_fl <= rates[3];
            m_speed_fr <= rates[4];
            m_speed_rl <= rates[5];
            m_speed_rr <= rates[6];
        end
    end

    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a transaction is in progress");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending transaction");
    a_capture_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> s_valid && s_ready)
        else $error("capture without an accepted transaction");
`endif
endmodule
`default_nettype wire

### src/mqo_ctrl.sv
// Sequencer for the odometry datapath.
`default_nettype none
module mqo_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  mqo_pkg::status_t       status,
    output logic                   s_ready,
    output mqo_pkg::cmd_t          cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_WHEEL  = 4'd2;
    localparam logic [3:0] S_SUMS   = 4'd3;
    localparam logic [3:0] S_PROD   = 4'd4;
    localparam logic [3:0] S_CORDIC = 4'd5;
    localparam logic [3:0] S_GAIN   = 4'd6;
    localparam logic [3:0] S_POSE   = 4'd7;
    localparam logic [3:0] S_RLOAD  = 4'd8;
    localparam logic [3:0] S_RMULLO = 4'd9;
    localparam logic [3:0] S_RMULHI = 4'd10;
    localparam logic [3:0] S_RCHK   = 4'd11;
    localparam logic [3:0] S_RDIV   = 4'd12;
    localparam logic [3:0] S_RSTORE = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    localparam logic [4:0] CORDIC_LAST = 5'(mqo_pkg::CORDIC_STEPS - 1);
    localparam logic [4:0] DIV_LAST    = 5'(mqo_pkg::DIV_STEPS - 1);
    localparam logic [2:0] WHEEL_LAST  = 3'(mqo_pkg::NUM_WHEELS - 1);

    logic [3:0] state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic [2:0] sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            sel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        sel_next     = sel_reg;
        s_ready      = 1'b0;
        cmd.capture  = 1'b0;
        cmd.op       = mqo_pkg::OP_NONE;
        cmd.step     = step_reg;
        cmd.sel      = sel_reg;
        cmd.load_out = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) state_next = S_DECODE;
            end
            S_DECODE: begin
                sel_next = '0;
                if (!status.kind) begin
                    cmd.op     = mqo_pkg::OP_SAMPLE;
                    state_next = S_IDLE;
                end else if (status.dt_zero) begin
                    state_next = S_IDLE;
                end else begin
                    state_next = S_WHEEL;
                end
            end
            S_WHEEL: begin
                cmd.op = mqo_pkg::OP_WHEEL;
                if (sel_reg == WHEEL_LAST) begin
                    sel_next   = '0;
                    state_next = S_SUMS;
                end else begin
                    sel_next = sel_reg + 3'd1;
                end
            end
            S_SUMS: begin
                cmd.op     = mqo_pkg::OP_SUMS;
                state_next = S_PROD;
            end
            S_PROD: begin
                cmd.op     = mqo_pkg::OP_PROD;
                step_next  = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC: begin
                cmd.op = mqo_pkg::OP_CORDIC;
                if (step_reg == CORDIC_LAST) begin
                    step_next  = '0;
                    state_next = S_GAIN;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_GAIN: begin
                cmd.op     = mqo_pkg::OP_GAIN;
                state_next = S_POSE;
            end
            S_POSE: begin
                cmd.op     = mqo_pkg::OP_POSE;
                sel_next   = mqo_pkg::RATE_VX;
                state_next = S_RLOAD;
            end
            S_RLOAD: begin
                cmd.op     = mqo_pkg::OP_RLOAD;
                state_next = S_RMULLO;
            end
            S_RMULLO: begin
                cmd.op     = mqo_pkg::OP_RMULLO;
                state_next = S_RMULHI;
            end
            S_RMULHI: begin
                cmd.op     = mqo_pkg::OP_RMULHI;
                state_next = S_RCHK;
            end
            S_RCHK: begin
                cmd.op     = mqo_pkg::OP_RCHK;
                step_next  = '0;
                state_next = S_RDIV;
            end
            S_RDIV: begin
                cmd.op = mqo_pkg::OP_RDIV;
                if (step_reg == DIV_LAST) begin
                    step_next  = '0;
                    state_next = S_RSTORE;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            S_RSTORE: begin
                cmd.op = mqo_pkg::OP_RSTORE;
                if (sel_reg == mqo_pkg::RATE_LAST) begin
                    state_next = S_DONE;
                end else begin
                    sel_next   = sel_reg + 3'd1;
                    state_next = S_RLOAD;
                end
            end
            S_DONE: begin
                cmd.load_out = status.out_free;
                if (status.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

### src/mqo_datapath.sv
// Decoder counts, pose integration, CORDIC rotation and shared rate divider.
`default_nettype none
module mqo_datapath #(
    parameter int COUNT_BITS = mqo_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  mqo_pkg::cmd_t                                 cmd,
    input  wire logic                                     kind_in,
    input  wire logic [3:0]                               enc_a_in,
    input  wire logic [3:0]                               enc_b_in,
    input  wire logic [19:0]                              dt_in,
    input  wire logic [23:0]                              dpc,
    input  wire logic [15:0]                              gain,
    output logic                                          kind,
    output logic                                          dt_zero,
    output logic [31:0]                                   pose_x,
    output logic [31:0]                                   pose_y,
    output logic [31:0]                                   pose_heading,
    output logic [mqo_pkg::NUM_RATES-1:0][mqo_pkg::RATE_W-1:0] rates
);
    localparam int NW   = mqo_pkg::NUM_WHEELS;
    localparam int DW   = (COUNT_BITS > 32) ? COUNT_BITS : 32;
    localparam int RW   = mqo_pkg::ROT_W;
    localparam int SW   = mqo_pkg::SUM_W;
    localparam int AW   = mqo_pkg::ACC_W;
    localparam int ZW   = mqo_pkg::ZW;
    localparam logic signed [16:0] CGAIN   = 17'sd39797;
    localparam logic [22:0]        NUM_SPD = 23'd15625;
    localparam logic [22:0]        NUM_YAW = 23'd6283185;

    // input capture
    logic        kind_reg;
    logic [3:0]  a_reg, b_reg;
    logic [19:0] dt_reg;

    // decoder and pose state
    logic [COUNT_BITS-1:0] count_reg [NW];
    logic [COUNT_BITS-1:0] start_reg [NW];
    logic [1:0]            phase_reg [NW];
    logic                  primed_reg;
    logic [31:0]           pose_x_reg, pose_y_reg, head_reg;

    // working registers
    logic signed [mqo_pkg::DIST_W-1:0] d_reg [NW];
    logic signed [SW-1:0] sx_reg, sy_reg, sr_reg, p_reg;
    logic signed [RW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] z_reg;
    logic [31:0]          gx_reg, gy_reg;
    logic [41:0]          mag_reg;
    logic                 neg_reg, sat_reg;
    logic [AW-1:0]        acc_reg, dsh_reg;
    logic [22:0]          q_reg;
    logic [mqo_pkg::RATE_W-1:0] res_reg [mqo_pkg::NUM_RATES];

    // sample decode
    logic [1:0]            phase_new [NW];
    logic [1:0]            dir [NW];
    logic [COUNT_BITS-1:0] count_step [NW];

    always_comb begin
        for (int w = 0; w < NW; w++) begin
            phase_new[w]  = {a_reg[w], b_reg[w]};
            dir[w]        = mqo_pkg::quad_step({phase_reg[w], phase_new[w]});
            count_step[w] = count_reg[w];
            if (primed_reg && dir[w][0]) count_step[w] = count_reg[w] + COUNT_BITS'(1);
            else if (primed_reg && dir[w][1]) count_step[w] = count_reg[w] - COUNT_BITS'(1);
        end
    end

    // count delta and wheel distance
    logic [1:0]              widx;
    logic [COUNT_BITS-1:0]   diff;
    logic signed [DW-1:0]    diff_ext;
    logic [DW-32:0]          diff_top;
    logic                    fits;
    logic signed [31:0]      delta;
    logic signed [24:0]      dpc_s;
    logic signed [mqo_pkg::DIST_W-1:0] wheel_dist;

    assign widx     = cmd.sel[1:0];
    assign diff     = count_reg[widx] - start_reg[widx];
    assign diff_ext = DW'($signed(diff));
    assign diff_top = diff_ext[DW-1:31];
    assign fits     = (&diff_top) | ~(|diff_top);
    assign delta    = fits ? diff_ext[31:0]
                    : (diff_ext[DW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    assign dpc_s    = {1'b0, dpc};
    assign wheel_dist = delta * dpc_s;

    // sums and heading increment
    logic signed [SW-1:0] sx_next, sy_next, sr_next, p_next;
    logic signed [16:0]   gain_s;
    assign gain_s  = {1'b0, gain};
    assign sx_next = d_reg[0] + d_reg[1] + d_reg[2] + d_reg[3];
    assign sy_next = -d_reg[0] + d_reg[1] + d_reg[2] - d_reg[3];
    assign sr_next = -d_reg[0] + d_reg[1] - d_reg[2] + d_reg[3];
    assign p_next  = (sr_reg >>> 16) * gain_s;

    // rotation set-up: quarter turn plus residual angle
    logic [23:0]          ang_t;
    logic [1:0]           quad;
    logic signed [RW-1:0] fx, fy;
    logic signed [ZW-1:0] z0;
    assign ang_t = head_reg[31:8] + 24'h200000;
    assign quad  = ang_t[23:22];
    assign z0    = $signed({2'b00, ang_t[21:0]}) - 24'sh200000;
    assign fx    = RW'(sx_reg >>> 14);
    assign fy    = RW'(sy_reg >>> 14);

    // CORDIC step
    logic signed [RW-1:0] dx, dy;
    logic signed [ZW-1:0] at;
    assign dx = cy_reg >>> cmd.step;
    assign dy = cx_reg >>> cmd.step;
    assign at = $signed({2'b00, mqo_pkg::atan_lut(cmd.step)});

    // gain correction
    logic signed [63:0] gpx, gpy, gpx_r, gpy_r;
    assign gpx   = cx_reg * CGAIN;
    assign gpy   = cy_reg * CGAIN;
    assign gpx_r = gpx + 64'sd524288;
    assign gpy_r = gpy + 64'sd524288;

    // rate unit
    logic signed [SW-1:0]        rate_x;
    logic [SW-1:0]               mag;
    logic                        over_lim;
    logic [22:0]                 num;
    logic [mqo_pkg::DVS_W-1:0]   dvs;
    logic [1:0]                  rw_idx;
    logic [mqo_pkg::RATE_W-1:0]  qv, res_val;
    logic                        is_yaw;

    assign is_yaw = (cmd.sel == mqo_pkg::RATE_YAW);
    assign rw_idx = 2'(cmd.sel - mqo_pkg::RATE_FL);

    always_comb begin
        case (cmd.sel)
            mqo_pkg::RATE_VX:  rate_x = sx_reg;
            mqo_pkg::RATE_VY:  rate_x = sy_reg;
            mqo_pkg::RATE_YAW: rate_x = p_reg;
            default:           rate_x = d_reg[rw_idx];
        endcase
        case (cmd.sel)
            mqo_pkg::RATE_VX, mqo_pkg::RATE_VY: dvs = {4'b0, dt_reg, 12'b0};
            mqo_pkg::RATE_YAW:                  dvs = {dt_reg, 16'b0};
            default:                            dvs = {6'b0, dt_reg, 10'b0};
        endcase
    end

    assign mag      = rate_x[SW-1] ? -rate_x : rate_x;
    assign over_lim = is_yaw ? (|mag[SW-1:37]) : (|mag[SW-1:42]);
    assign num      = is_yaw ? NUM_YAW : NUM_SPD;
    assign qv       = {1'b0, q_reg};
    assign res_val  = sat_reg ? (neg_reg ? 24'h800000 : 24'h7FFFFF)
                    : (neg_reg ? -qv : qv);

    logic [43:0] mul_lo, mul_hi;
    assign mul_lo = mag_reg[20:0] * num;
    assign mul_hi = mag_reg[41:21] * num;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < NW; w++) begin
                count_reg[w] <= '0;
                start_reg[w] <= '0;
                phase_reg[w] <= '0;
            end
            primed_reg <= 1'b0;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            head_reg   <= '0;
        end else begin
            case (cmd.op)
                mqo_pkg::OP_SAMPLE: begin
                    for (int w = 0; w < NW; w++) begin
                        count_reg[w] <= count_step[w];
                        phase_reg[w] <= phase_new[w];
                    end
                    primed_reg <= 1'b1;
                end
                mqo_pkg::OP_WHEEL: begin
                    start_reg[widx] <= count_reg[widx];
                end
                mqo_pkg::OP_POSE: begin
                    pose_x_reg <= pose_x_reg + gx_reg;
                    pose_y_reg <= pose_y_reg + gy_reg;
                    head_reg   <= head_reg + p_reg[31:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= kind_in;
            a_reg    <= enc_a_in;
            b_reg    <= enc_b_in;
            dt_reg   <= dt_in;
        end
        case (cmd.op)
            mqo_pkg::OP_WHEEL: d_reg[widx] <= wheel_dist;
            mqo_pkg::OP_SUMS: begin
                sx_reg <= sx_next;
                sy_reg <= sy_next;
                sr_reg <= sr_next;
            end
            mqo_pkg::OP_PROD: begin
                p_reg <= p_next;
                z_reg <= z0;
                case (quad)
                    2'd1: begin
                        cx_reg <= -fy;
                        cy_reg <= fx;
                    end
                    2'd2: begin
                        cx_reg <= -fx;
                        cy_reg <= -fy;
                    end
                    2'd3: begin
                        cx_reg <= fy;
                        cy_reg <= -fx;
                    end
                    default: begin
                        cx_reg <= fx;
                        cy_reg <= fy;
                    end
                endcase
            end
            mqo_pkg::OP_CORDIC: begin
                if (!z_reg[ZW-1]) begin
                    cx_reg <= cx_reg - dx;
                    cy_reg <= cy_reg + dy;
                    z_reg  <= z_reg - at;
                end else begin
                    cx_reg <= cx_reg + dx;
                    cy_reg <= cy_reg - dy;
                    z_reg  <= z_reg + at;
                end
            end
            mqo_pkg::OP_GAIN: begin
                gx_reg <= gpx_r[51:20];
                gy_reg <= gpy_r[51:20];
            end
            mqo_pkg::OP_RLOAD: begin
                mag_reg <= mag[41:0];
                neg_reg <= rate_x[SW-1];
                sat_reg <= over_lim;
            end
            mqo_pkg::OP_RMULLO: acc_reg <= AW'(mul_lo);
            mqo_pkg::OP_RMULHI: acc_reg <= acc_reg + (AW'(mul_hi) << 21);
            mqo_pkg::OP_RCHK: begin
                dsh_reg <= AW'(dvs) << 22;
                q_reg   <= '0;
                if (acc_reg >= (AW'(dvs) << 23)) sat_reg <= 1'b1;
            end
            mqo_pkg::OP_RDIV: begin
                if (acc_reg >= dsh_reg) begin
                    acc_reg <= acc_reg - dsh_reg;
                    q_reg   <= {q_reg[21:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[21:0], 1'b0};
                end
                dsh_reg <= dsh_reg >> 1;
            end
            mqo_pkg::OP_RSTORE: res_reg[cmd.sel] <= res_val;
            default: begin
            end
        endcase
    end

    assign kind         = kind_reg;
    assign dt_zero      = (dt_reg == 20'd0);
    assign pose_x       = pose_x_reg;
    assign pose_y       = pose_y_reg;
    assign pose_heading = head_reg;

    always_comb begin
        for (int r = 0; r < mqo_pkg::NUM_RATES; r++) rates[r] = res_reg[r];
    end
endmodule
`default_nettype wire
